@@ rtl/dtfb_pkg.sv @@
// Shared types, codes and constants of the dirty-tracking frame buffer.
`timescale 1ns / 1ps
`default_nettype none

package dtfb_pkg;

    // Default store geometry.
    localparam int DEF_MAIN_WIDTH  = 10;
    localparam int DEF_MAIN_HEIGHT = 20;
    localparam int DEF_MINI_WIDTH  = 4;
    localparam int DEF_MINI_HEIGHT = 4;

    // Width of address arithmetic; covers the largest legal geometry.
    localparam int CALC_W = 10;
    // Width used for bounds compares of column and row.
    localparam int CMP_W  = 6;

    // Entry layout: dirty mark in bit 7, color below it.
    localparam logic [7:0] DIRTY_MARK = 8'h80;
    localparam logic [7:0] COLOR_MASK = 8'h7F;
    localparam logic [7:0] END_MARK   = 8'hFE;

    // Command codes.
    localparam logic [3:0] CMD_CLEAR_MAIN = 4'd0;
    localparam logic [3:0] CMD_CLEAR_MINI = 4'd1;
    localparam logic [3:0] CMD_SET_MAIN   = 4'd2;
    localparam logic [3:0] CMD_SET_MINI   = 4'd3;
    localparam logic [3:0] CMD_FILL_ROW   = 4'd4;
    localparam logic [3:0] CMD_WIPE_ROW   = 4'd5;
    localparam logic [3:0] CMD_FREE_Q     = 4'd6;
    localparam logic [3:0] CMD_FILLED_Q   = 4'd7;
    localparam logic [3:0] CMD_FLUSH      = 4'd8;

    // Result kinds.
    localparam logic [1:0] KIND_ANSWER = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic       answer;
        logic [7:0] pixel_index;
        logic [6:0] out_color;
        logic       last;
    } res_t;

    // Access request from the sequencer to the pixel memory.
    typedef struct packed {
        logic              we;
        logic [CALC_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [CALC_W-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/dtfb_mem.sv @@
// Pixel memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dtfb_mem #(
    parameter int DEPTH = dtfb_pkg::DEF_MAIN_WIDTH * dtfb_pkg::DEF_MAIN_HEIGHT
                        + dtfb_pkg::DEF_MINI_WIDTH * dtfb_pkg::DEF_MINI_HEIGHT
) (
    input  wire                    aclk,
    input  dtfb_pkg::mem_req_t     req,
    output logic [7:0]             rdata
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[IDX_W-1:0]] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr[IDX_W-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/dtfb_out.sv @@
// Output register that holds one result until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module dtfb_out (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 load,
    input  dtfb_pkg::res_t      res,
    output logic                free,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [15:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);

    logic           valid_reg;
    dtfb_pkg::res_t data_reg;

    // The slot is free when empty or when its result leaves this cycle.
    assign free = !valid_reg || m_tready;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.out_color, data_reg.pixel_index, data_reg.answer};
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.last;

endmodule

`default_nettype wire

@@ rtl/dtfb_ctrl.sv @@
// Command sequencer: walks the pixel memory with read-modify-write steps.
`timescale 1ns / 1ps
`default_nettype none

module dtfb_ctrl #(
    parameter int MAIN_WIDTH  = dtfb_pkg::DEF_MAIN_WIDTH,
    parameter int MAIN_HEIGHT = dtfb_pkg::DEF_MAIN_HEIGHT,
    parameter int MINI_WIDTH  = dtfb_pkg::DEF_MINI_WIDTH,
    parameter int MINI_HEIGHT = dtfb_pkg::DEF_MINI_HEIGHT
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  [3:0]           cmd,
    input  wire  [3:0]           column,
    input  wire  [4:0]           row,
    input  wire  [6:0]           pixel_color,
    output dtfb_pkg::mem_req_t   mem_req,
    input  wire  [7:0]           rdata,
    output logic                 res_load,
    output dtfb_pkg::res_t       res,
    input  wire                  res_free
);

    localparam int MAIN_SIZE = MAIN_WIDTH * MAIN_HEIGHT;
    localparam int MINI_SIZE = MINI_WIDTH * MINI_HEIGHT;
    localparam int TOTAL     = MAIN_SIZE + MINI_SIZE;
    localparam int CNT_W     = $clog2(TOTAL + 1);
    localparam int CW        = dtfb_pkg::CALC_W;
    localparam int MW        = dtfb_pkg::CMP_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WRITE = 4'd1;
    localparam logic [3:0] S_WRD   = 4'd2;
    localparam logic [3:0] S_WWR   = 4'd3;
    localparam logic [3:0] S_QRD   = 4'd4;
    localparam logic [3:0] S_QEV   = 4'd5;
    localparam logic [3:0] S_FRD   = 4'd6;
    localparam logic [3:0] S_FEV   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] end_reg, end_next;
    logic [7:0]       wval_reg, wval_next;
    logic [CNT_W-1:0] fptr_reg, fptr_next;
    logic             qfree_reg, qfree_next;
    logic             ans_reg, ans_next;
    dtfb_pkg::res_t   res_reg, res_next;

    logic [CW-1:0]    row_base;
    logic [CW-1:0]    main_addr;
    logic [CW-1:0]    mini_addr;
    logic [CW-1:0]    cnt_ext;
    logic             main_ok;
    logic             mini_ok;
    logic             row_ok;
    logic             color_zero;

    // Address and bounds decode of the incoming item.
    assign row_base  = CW'(row) * CW'(MAIN_WIDTH);
    assign main_addr = row_base + CW'(column);
    assign mini_addr = CW'(MAIN_SIZE) + CW'(row) * CW'(MINI_WIDTH) + CW'(column);
    assign row_ok    = MW'(row) < MW'(MAIN_HEIGHT);
    assign main_ok   = row_ok && (MW'(column) < MW'(MAIN_WIDTH));
    assign mini_ok   = (MW'(row) < MW'(MINI_HEIGHT)) && (MW'(column) < MW'(MINI_WIDTH));
    assign cnt_ext   = CW'(cnt_reg);
    assign color_zero = (rdata & dtfb_pkg::COLOR_MASK) == 8'h00;

    assign in_ready = state_reg == S_IDLE;
    assign res      = res_reg;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        end_next   = end_reg;
        wval_next  = wval_reg;
        fptr_next  = fptr_reg;
        qfree_next = qfree_reg;
        ans_next   = ans_reg;
        res_next   = res_reg;
        res_load   = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = cnt_ext;
        mem_req.wdata = wval_reg;
        mem_req.raddr = cnt_ext;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    res_next.kind        = dtfb_pkg::KIND_ANSWER;
                    res_next.answer      = 1'b0;
                    res_next.pixel_index = 8'h00;
                    res_next.out_color   = 7'h00;
                    res_next.last        = 1'b0;
                    unique case (cmd)
                        dtfb_pkg::CMD_CLEAR_MAIN: begin
                            cnt_next   = '0;
                            end_next   = CNT_W'(MAIN_SIZE - 1);
                            wval_next  = dtfb_pkg::DIRTY_MARK;
                            state_next = S_WRITE;
                        end
                        dtfb_pkg::CMD_CLEAR_MINI: begin
                            cnt_next   = CNT_W'(MAIN_SIZE);
                            end_next   = CNT_W'(TOTAL - 1);
                            wval_next  = dtfb_pkg::DIRTY_MARK;
                            state_next = S_WRITE;
                        end
                        dtfb_pkg::CMD_SET_MAIN: begin
                            cnt_next   = CNT_W'(main_addr);
                            end_next   = CNT_W'(main_addr);
                            wval_next  = {1'b1, pixel_color};
                            if (main_ok) begin
                                state_next = S_WRITE;
                            end
                        end
                        dtfb_pkg::CMD_SET_MINI: begin
                            cnt_next   = CNT_W'(mini_addr);
                            end_next   = CNT_W'(mini_addr);
                            wval_next  = {1'b1, pixel_color};
                            if (mini_ok) begin
                                state_next = S_WRITE;
                            end
                        end
                        dtfb_pkg::CMD_FILL_ROW: begin
                            cnt_next   = CNT_W'(row_base);
                            end_next   = CNT_W'(row_base + CW'(MAIN_WIDTH - 1));
                            wval_next  = {1'b1, pixel_color};
                            if (row_ok) begin
                                state_next = S_WRITE;
                            end
                        end
                        dtfb_pkg::CMD_WIPE_ROW: begin
                            wval_next = dtfb_pkg::DIRTY_MARK;
                            end_next  = CNT_W'(MAIN_WIDTH - 1);
                            if (row == 5'd0) begin
                                // Top row only: just blank it.
                                cnt_next   = '0;
                                state_next = S_WRITE;
                            end else begin
                                // Start at the last source entry and move down.
                                cnt_next = CNT_W'(row_base - CW'(1));
                                if (row_ok) begin
                                    state_next = S_WRD;
                                end
                            end
                        end
                        dtfb_pkg::CMD_FREE_Q: begin
                            cnt_next   = CNT_W'(main_addr);
                            end_next   = CNT_W'(main_addr);
                            qfree_next = 1'b1;
                            ans_next   = 1'b1;
                            state_next = main_ok ? S_QRD : S_EMIT;
                        end
                        dtfb_pkg::CMD_FILLED_Q: begin
                            cnt_next   = CNT_W'(row_base);
                            end_next   = CNT_W'(row_base + CW'(MAIN_WIDTH - 1));
                            qfree_next = 1'b0;
                            ans_next   = 1'b1;
                            state_next = row_ok ? S_QRD : S_EMIT;
                        end
                        dtfb_pkg::CMD_FLUSH: begin
                            cnt_next = fptr_reg;
                            if (fptr_reg == CNT_W'(TOTAL)) begin
                                fptr_next            = '0;
                                res_next.kind        = dtfb_pkg::KIND_END;
                                res_next.pixel_index = dtfb_pkg::END_MARK;
                                res_next.last        = 1'b1;
                                state_next           = S_EMIT;
                            end else begin
                                state_next = S_FRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Write one entry a cycle from cnt up to end (also the reset pass).
            S_WRITE: begin
                mem_req.we = 1'b1;
                if (cnt_reg == end_reg) begin
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Wipe: read the source entry one row above the target.
            S_WRD: begin
                state_next = S_WWR;
            end

            // Wipe: move it down one row and mark it dirty.
            S_WWR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_ext + CW'(MAIN_WIDTH);
                mem_req.wdata = rdata | dtfb_pkg::DIRTY_MARK;
                if (cnt_reg == '0) begin
                    // Then blank the top row.
                    end_next   = CNT_W'(MAIN_WIDTH - 1);
                    state_next = S_WRITE;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_WRD;
                end
            end

            // Queries: read one entry.
            S_QRD: begin
                state_next = S_QEV;
            end

            // Queries: test the color, ignoring the mark.
            S_QEV: begin
                if (qfree_reg) begin
                    ans_next = color_zero;
                end else begin
                    ans_next = ans_reg && !color_zero;
                end
                if (cnt_reg == end_reg) begin
                    res_next.answer = qfree_reg ? color_zero : (ans_reg && !color_zero);
                    state_next      = S_EMIT;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_QRD;
                end
            end

            // Flush: read the entry under the scan pointer.
            S_FRD: begin
                state_next = S_FEV;
            end

            // Flush: send a dirty entry and clear its mark, or go on.
            S_FEV: begin
                mem_req.wdata = rdata & dtfb_pkg::COLOR_MASK;
                if (rdata[7]) begin
                    mem_req.we           = 1'b1;
                    fptr_next            = cnt_reg + 1'b1;
                    res_next.kind        = dtfb_pkg::KIND_UPDATE;
                    res_next.pixel_index = cnt_ext[7:0];
                    res_next.out_color   = rdata[6:0];
                    state_next           = S_EMIT;
                end else if (cnt_reg == CNT_W'(TOTAL - 1)) begin
                    fptr_next            = '0;
                    res_next.kind        = dtfb_pkg::KIND_END;
                    res_next.pixel_index = dtfb_pkg::END_MARK;
                    res_next.last        = 1'b1;
                    state_next           = S_EMIT;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_FRD;
                end
            end

            // Hand the result to the output register once it has room.
            S_EMIT: begin
                if (res_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the pass that marks every entry dirty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_WRITE;
            cnt_reg   <= '0;
            end_reg   <= CNT_W'(TOTAL - 1);
            wval_reg  <= dtfb_pkg::DIRTY_MARK;
            fptr_reg  <= '0;
            qfree_reg <= 1'b0;
            ans_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            end_reg   <= end_next;
            wval_reg  <= wval_next;
            fptr_reg  <= fptr_next;
            qfree_reg <= qfree_next;
            ans_reg   <= ans_next;
        end
    end

    // Pending result payload.
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

@@ rtl/dirty_tracking_framebuffer_core.sv @@
// Top level of the dirty-tracking frame buffer.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata (low bit up)                          tuser     tlast
// s_       in   column[3:0] row[8:4] pixel_color[15:9]       cmd[3:0]  -
// m_       out  answer[0] pixel_index[8:1] out_color[15:9]   kind[1:0] last
//
// One command at a time runs in a sequencer around one pixel memory (main store,
// then mini store). After reset a pass marks every entry dirty; s_tready stays
// low until it ends. A finished result waits in an output register, and a
// stalled sink holds the sequencer only when that register is still full.
module dirty_tracking_framebuffer_core #(
    parameter int MAIN_WIDTH  = dtfb_pkg::DEF_MAIN_WIDTH,
    parameter int MAIN_HEIGHT = dtfb_pkg::DEF_MAIN_HEIGHT,
    parameter int MINI_WIDTH  = dtfb_pkg::DEF_MINI_WIDTH,
    parameter int MINI_HEIGHT = dtfb_pkg::DEF_MINI_HEIGHT
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // column[3:0], row[8:4], pixel_color[15:9]
    input  wire  [3:0]  s_tuser,   // cmd[3:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // answer[0], pixel_index[8:1], out_color[15:9]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    localparam int DEPTH = MAIN_WIDTH * MAIN_HEIGHT + MINI_WIDTH * MINI_HEIGHT;

    dtfb_pkg::mem_req_t mem_req;
    dtfb_pkg::res_t     res;
    logic [7:0]         rdata;
    logic               res_load;
    logic               res_free;

    // Command sequencer.
    dtfb_ctrl #(
        .MAIN_WIDTH  (MAIN_WIDTH),
        .MAIN_HEIGHT (MAIN_HEIGHT),
        .MINI_WIDTH  (MINI_WIDTH),
        .MINI_HEIGHT (MINI_HEIGHT)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .cmd         (s_tuser),
        .column      (s_tdata[3:0]),
        .row         (s_tdata[8:4]),
        .pixel_color (s_tdata[15:9]),
        .mem_req     (mem_req),
        .rdata       (rdata),
        .res_load    (res_load),
        .res         (res),
        .res_free    (res_free)
    );

    // Pixel memory for both stores.
    dtfb_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // Result output register.
    dtfb_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .res      (res),
        .free     (res_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ verif/dirty_tracking_framebuffer_core_tb.sv @@
// Self-checking testbench for the dirty-tracking frame buffer core.
`timescale 1ns / 1ps

// Shadow copy of both pixel stores and the flush pointer, and the queue of
// results that the block still owes.
class frame_delta_tracker;
    localparam int MAIN_W    = dtfb_pkg::DEF_MAIN_WIDTH;
    localparam int MAIN_H    = dtfb_pkg::DEF_MAIN_HEIGHT;
    localparam int MINI_W    = dtfb_pkg::DEF_MINI_WIDTH;
    localparam int MINI_H    = dtfb_pkg::DEF_MINI_HEIGHT;
    localparam int MAIN_SIZE = MAIN_W * MAIN_H;
    localparam int MINI_SIZE = MINI_W * MINI_H;

    logic [7:0]      main_px [MAIN_SIZE];
    logic [7:0]      mini_px [MINI_SIZE];
    int unsigned     scan_ptr;
    dtfb_pkg::res_t  owed_results[$];
    int unsigned     errors;
    bit              scan_wrapped;

    function new();
        foreach (main_px[i]) main_px[i] = dtfb_pkg::DIRTY_MARK;
        foreach (mini_px[i]) mini_px[i] = dtfb_pkg::DIRTY_MARK;
        scan_ptr     = 0;
        errors       = 0;
        scan_wrapped = 1'b0;
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    task report(string what);
        if (errors < 100) $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Applies one accepted command to the shadow stores and queues its result.
    function void note_command(logic [3:0] op, logic [3:0] col, logic [4:0] row,
                               logic [6:0] color);
        dtfb_pkg::res_t r;
        int             base;
        bit             hit;
        r    = '0;
        base = int'(row) * MAIN_W;
        case (op)
            dtfb_pkg::CMD_CLEAR_MAIN: foreach (main_px[i]) main_px[i] = dtfb_pkg::DIRTY_MARK;
            dtfb_pkg::CMD_CLEAR_MINI: foreach (mini_px[i]) mini_px[i] = dtfb_pkg::DIRTY_MARK;
            dtfb_pkg::CMD_SET_MAIN: begin
                if (col < MAIN_W && row < MAIN_H)
                    main_px[base + col] = {1'b1, color};
            end
            dtfb_pkg::CMD_SET_MINI: begin
                if (col < MINI_W && row < MINI_H)
                    mini_px[int'(row) * MINI_W + col] = {1'b1, color};
            end
            dtfb_pkg::CMD_FILL_ROW: begin
                if (row < MAIN_H)
                    for (int c = 0; c < MAIN_W; c++) main_px[base + c] = {1'b1, color};
            end
            dtfb_pkg::CMD_WIPE_ROW: begin
                // Rows above the wiped one move down a row and become dirty.
                if (row < MAIN_H) begin
                    for (int i = base + MAIN_W - 1; i >= MAIN_W; i--)
                        main_px[i] = main_px[i - MAIN_W] | dtfb_pkg::DIRTY_MARK;
                    for (int i = 0; i < MAIN_W; i++) main_px[i] = dtfb_pkg::DIRTY_MARK;
                end
            end
            dtfb_pkg::CMD_FREE_Q: begin
                r.kind = dtfb_pkg::KIND_ANSWER;
                if (col < MAIN_W && row < MAIN_H)
                    r.answer = (main_px[base + col][6:0] == 7'd0);
                owed_results.push_back(r);
            end
            dtfb_pkg::CMD_FILLED_Q: begin
                r.kind = dtfb_pkg::KIND_ANSWER;
                if (row < MAIN_H) begin
                    r.answer = 1'b1;
                    for (int c = 0; c < MAIN_W; c++)
                        if (main_px[base + c][6:0] == 7'd0) r.answer = 1'b0;
                end
                owed_results.push_back(r);
            end
            dtfb_pkg::CMD_FLUSH: begin
                // Send the first dirty entry at or after the pointer, else the end mark.
                hit = 1'b0;
                for (int i = scan_ptr; i < MAIN_SIZE + MINI_SIZE && !hit; i++) begin
                    if (i < MAIN_SIZE && main_px[i][7]) begin
                        main_px[i][7] = 1'b0;
                        r.out_color   = main_px[i][6:0];
                        hit           = 1'b1;
                    end else if (i >= MAIN_SIZE && mini_px[i - MAIN_SIZE][7]) begin
                        mini_px[i - MAIN_SIZE][7] = 1'b0;
                        r.out_color               = mini_px[i - MAIN_SIZE][6:0];
                        hit                       = 1'b1;
                    end
                    if (hit) begin
                        r.kind        = dtfb_pkg::KIND_UPDATE;
                        r.pixel_index = 8'(i);
                        scan_ptr      = i + 1;
                    end
                end
                if (!hit) begin
                    r.kind        = dtfb_pkg::KIND_END;
                    r.pixel_index = dtfb_pkg::END_MARK;
                    r.last        = 1'b1;
                    scan_ptr      = 0;
                end
                scan_wrapped = !hit;
                owed_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // Compares one result transfer with the oldest owed result.
    task check_result(dtfb_pkg::res_t got);
        dtfb_pkg::res_t want;
        if (owed_results.size() == 0) begin
            report($sformatf("unexpected result kind=%0d index=%0d", got.kind,
                             got.pixel_index));
        end else begin
            want = owed_results.pop_front();
            if (got.kind != want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.answer != want.answer)
                report($sformatf("answer %0d, expected %0d", got.answer, want.answer));
            if (got.pixel_index != want.pixel_index)
                report($sformatf("pixel_index %0d, expected %0d", got.pixel_index,
                                 want.pixel_index));
            if (got.out_color != want.out_color)
                report($sformatf("out_color %0d, expected %0d", got.out_color,
                                 want.out_color));
            if (got.last != want.last)
                report($sformatf("last %0d, expected %0d", got.last, want.last));
        end
    endtask
endclass

module dirty_tracking_framebuffer_core_tb;

    localparam int MAIN_W      = dtfb_pkg::DEF_MAIN_WIDTH;
    localparam int MAIN_H      = dtfb_pkg::DEF_MAIN_HEIGHT;
    localparam int MINI_W      = dtfb_pkg::DEF_MINI_WIDTH;
    localparam int MINI_H      = dtfb_pkg::DEF_MINI_HEIGHT;
    localparam int ITEM_TARGET = 450;
    localparam int TAIL_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    frame_delta_tracker tracker = new();
    int unsigned        sent_items = 0;
    int unsigned        cycles     = 0;
    bit                 tx_quiet   = 1'b0;
    bit                 rx_quiet   = 1'b0;

    dirty_tracking_framebuffer_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one command and waits for its transfer.
    task automatic send_cmd(logic [3:0] op, logic [3:0] col, logic [4:0] row,
                            logic [6:0] color);
        int gap;
        gap = tx_quiet ? 0 : pick_pause();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {color, row, col};
        do @(posedge aclk); while (!s_tready);
        tracker.note_command(op, col, row, color);
        sent_items++;
    endtask

    // Holds the input back until every owed result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    // Flush steps until the end mark comes back or the item budget is spent.
    task automatic flush_until_end();
        do begin
            send_cmd(dtfb_pkg::CMD_FLUSH, 4'($urandom), 5'($urandom), 7'($urandom));
        end while (!tracker.scan_wrapped && sent_items < ITEM_TARGET);
    endtask

    // One random command, mostly inside the stores.
    task automatic send_random_edit();
        int         r;
        logic [3:0] op;
        logic [3:0] col;
        logic [4:0] row;
        logic [6:0] color;
        r     = $urandom_range(0, 99);
        col   = 4'($urandom_range(0, 15));
        row   = 5'($urandom_range(0, 31));
        color = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 4) == 0) color = '0;
        if (r < 2)       op = dtfb_pkg::CMD_CLEAR_MAIN;
        else if (r < 5)  op = dtfb_pkg::CMD_CLEAR_MINI;
        else if (r < 35) op = dtfb_pkg::CMD_SET_MAIN;
        else if (r < 45) op = dtfb_pkg::CMD_SET_MINI;
        else if (r < 55) op = dtfb_pkg::CMD_FILL_ROW;
        else if (r < 62) op = dtfb_pkg::CMD_WIPE_ROW;
        else if (r < 74) op = dtfb_pkg::CMD_FREE_Q;
        else if (r < 84) op = dtfb_pkg::CMD_FILLED_Q;
        else if (r < 93) op = dtfb_pkg::CMD_FLUSH;
        else             op = 4'(dtfb_pkg::CMD_FLUSH + $urandom_range(1, 7));
        if ($urandom_range(0, 5) != 0) begin
            if (op == dtfb_pkg::CMD_SET_MINI) begin
                col = 4'(col % MINI_W);
                row = 5'(row % MINI_H);
            end else begin
                col = 4'(col % MAIN_W);
                row = 5'(row % MAIN_H);
            end
        end
        send_cmd(op, col, row, color);
    endtask

    // Result side: check every transfer and stall at random.
    initial begin : result_sink
        int             stall;
        dtfb_pkg::res_t got;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.kind        = m_tuser;
                got.answer      = m_tdata[0];
                got.pixel_index = m_tdata[8:1];
                got.out_color   = m_tdata[15:9];
                got.last        = m_tlast;
                tracker.check_result(got);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!rx_quiet) stall = pick_pause();
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int episode;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, every command and the boundary cases.
        send_cmd(dtfb_pkg::CMD_FLUSH, 4'd0, 5'd0, 7'd0);
        send_cmd(dtfb_pkg::CMD_FREE_Q, 4'd5, 5'd5, 7'd0);
        send_cmd(dtfb_pkg::CMD_SET_MAIN, 4'd0, 5'd0, 7'h7F);
        send_cmd(dtfb_pkg::CMD_SET_MAIN, 4'(MAIN_W - 1), 5'(MAIN_H - 1), 7'd1);
        send_cmd(dtfb_pkg::CMD_SET_MAIN, 4'(MAIN_W), 5'd0, 7'h55);
        send_cmd(dtfb_pkg::CMD_SET_MAIN, 4'd0, 5'(MAIN_H), 7'h2A);
        send_cmd(dtfb_pkg::CMD_SET_MINI, 4'(MINI_W - 1), 5'(MINI_H - 1), 7'h55);
        send_cmd(dtfb_pkg::CMD_SET_MINI, 4'(MINI_W), 5'd0, 7'h2A);
        send_cmd(dtfb_pkg::CMD_SET_MINI, 4'hF, 5'h1F, 7'h7F);
        send_cmd(dtfb_pkg::CMD_FILL_ROW, 4'd0, 5'd0, 7'h2A);
        send_cmd(dtfb_pkg::CMD_FILL_ROW, 4'd0, 5'(MAIN_H - 1), 7'h7F);
        send_cmd(dtfb_pkg::CMD_FILL_ROW, 4'd0, 5'(MAIN_H), 7'h11);
        send_cmd(dtfb_pkg::CMD_FILLED_Q, 4'd0, 5'd0, 7'd0);
        send_cmd(dtfb_pkg::CMD_FILLED_Q, 4'd0, 5'd5, 7'd0);
        send_cmd(dtfb_pkg::CMD_FILLED_Q, 4'd0, 5'h1F, 7'd0);
        send_cmd(dtfb_pkg::CMD_FREE_Q, 4'd0, 5'd0, 7'd0);
        send_cmd(dtfb_pkg::CMD_FREE_Q, 4'hF, 5'd0, 7'd0);
        send_cmd(dtfb_pkg::CMD_WIPE_ROW, 4'd0, 5'(MAIN_H - 1), 7'd0);
        send_cmd(dtfb_pkg::CMD_WIPE_ROW, 4'd0, 5'd0, 7'd0);
        send_cmd(dtfb_pkg::CMD_WIPE_ROW, 4'd0, 5'd25, 7'd0);
        send_cmd(4'(dtfb_pkg::CMD_FLUSH + 1), 4'hF, 5'h1F, 7'h7F);
        send_cmd(4'(dtfb_pkg::CMD_FLUSH + 7), 4'hF, 5'h1F, 7'h7F);
        send_cmd(dtfb_pkg::CMD_CLEAR_MAIN, 4'd0, 5'd0, 7'd0);
        send_cmd(dtfb_pkg::CMD_CLEAR_MINI, 4'd0, 5'd0, 7'd0);
        send_cmd(dtfb_pkg::CMD_FLUSH, 4'hF, 5'h1F, 7'h7F);
        drain_results();

        // Random: bursts of edits and queries, most followed by a full flush.
        episode = 0;
        flush_until_end();
        while (sent_items < ITEM_TARGET) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 8)) send_random_edit();
            if ($urandom_range(0, 3) != 0) flush_until_end();
            if (episode % 10 == 5) drain_results();
            episode++;
        end

        // Wait out owed results, then watch for stray ones.
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.pending() != 0) tracker.report("results still owed at the end");
        if (tracker.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
